FILE: rtl/core/pfg_pkg.sv
package pfg_pkg;

  localparam int unsigned DEFAULT_PANCAKE_COUNT = 16;

  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned VAL_W     = 5;
  localparam int unsigned BOUND_W   = 5;
  localparam int unsigned G_W       = 8;
  localparam int unsigned F_W       = 9;
  localparam int unsigned FBAR_W    = 11;
  localparam int unsigned GI_W      = 6;
  // wide enough for pancake values and the virtual bottom pancake N+1
  localparam int unsigned CMP_W     = 8;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  localparam logic [1:0] REG_GAP_IGNORE     = 2'd0;
  localparam logic [1:0] REG_SEARCH_FORWARD = 2'd1;
  localparam logic [1:0] REG_DUAL_PRESENT   = 2'd2;

  localparam logic [ACTION_W-1:0] ACT_LOAD_STACK = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_DUAL  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_EVAL       = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_FLIP       = 2'd3;

  typedef enum logic [2:0] {
    RK_NONE,
    RK_FIRST,
    RK_MID,
    RK_LAST,
    RK_TOP,
    RK_AT,
    RK_BELOW
  } rd_kind_e;

  typedef enum logic [1:0] {
    WS_VALUE,
    WS_RDATA,
    WS_TMP
  } wr_src_e;

  typedef struct packed {
    logic [GI_W-1:0] gap_ignore;
    logic            search_forward;
    logic            dual_present;
  } cfg_t;

  typedef struct packed {
    logic     take;
    logic     stk_we;
    logic     dual_we;
    wr_src_e  wr_src;
    rd_kind_e rd_kind;
    logic     tmp_load;
    logic     flip_upd;
    logic     below_virtual;
    logic     out_load;
    logic     status;
  } cmd_t;

  function automatic logic gap_far(logic [CMP_W-1:0] x, logic [CMP_W-1:0] y);
    logic [CMP_W-1:0] d;
    d = (x > y) ? (x - y) : (y - x);
    return d > CMP_W'(1);
  endfunction

  function automatic logic is_ignored(logic [CMP_W-1:0] v, logic [GI_W-1:0] gi);
    return $signed({1'b0, v}) <= $signed({{(CMP_W + 1 - GI_W){gi[GI_W-1]}}, gi});
  endfunction

  function automatic logic [BOUND_W-1:0] sat_add(logic [BOUND_W-1:0] base, logic [1:0] inc);
    logic [BOUND_W:0] s;
    s = {1'b0, base} + (BOUND_W + 1)'(inc);
    return s[BOUND_W] ? {BOUND_W{1'b1}} : s[BOUND_W-1:0];
  endfunction

  // bound change from the one adjacency a prefix flip alters
  function automatic logic [BOUND_W-1:0] step_bound(
    logic [BOUND_W-1:0] lb,
    logic               ign_t,
    logic               ign_a,
    logic               ign_b,
    logic [CMP_W-1:0]   vt,
    logic [CMP_W-1:0]   va,
    logic [CMP_W-1:0]   vb
  );
    logic inc;
    logic dec;
    logic [BOUND_W-1:0] r;
    inc = ign_a || ign_b || !gap_far(vb, va);
    dec = ign_t || ign_b || !gap_far(vb, vt);
    r = lb;
    if (inc && !dec) begin
      r = (lb == {BOUND_W{1'b1}}) ? lb : lb + BOUND_W'(1);
    end else if (dec && !inc) begin
      r = (lb == '0) ? lb : lb - BOUND_W'(1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/pfg_intf.sv
interface pfg_item_if;
  logic                               valid;
  logic                               ready;
  logic [pfg_pkg::ACTION_W-1:0]       action;
  logic [pfg_pkg::POS_W-1:0]          position;
  logic [pfg_pkg::VAL_W-1:0]          value;

  modport source (output valid, action, position, value, input ready);
  modport sink (input valid, action, position, value, output ready);
endinterface

interface pfg_result_if;
  logic                               valid;
  logic                               ready;
  logic                               status;
  logic [pfg_pkg::BOUND_W-1:0]        h_cost;
  logic [pfg_pkg::BOUND_W-1:0]        h_other;
  logic [pfg_pkg::G_W-1:0]            g_cost;
  logic [pfg_pkg::F_W-1:0]            f_cost;
  logic signed [pfg_pkg::FBAR_W-1:0]  f_bar;

  modport source (output valid, status, h_cost, h_other, g_cost, f_cost, f_bar,
                  input ready);
  modport sink (input valid, status, h_cost, h_other, g_cost, f_cost, f_bar,
                output ready);
endinterface

FILE: rtl/core/pancake_flip_gap_heuristic_unit.sv
// a load writes one table entry, a rejected flip goes straight to the result, evaluate
// streams the stack one entry a cycle, and a flip reads the top, position p and the entry
// below p (none when p equals N), updates the bounds, then reverses the prefix by pair swaps;
// one transaction at a time, the next taken the cycle after the result registers
// reset (async, active low) clears control, bounds, flip count and config
// (gap_ignore 0, search_forward 1, dual_present 0); stack and dual tables are not cleared
module pancake_flip_gap_heuristic_unit #(
  parameter int unsigned PANCAKE_COUNT = pfg_pkg::DEFAULT_PANCAKE_COUNT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  pfg_item_if.sink                           item_i,
  pfg_result_if.source                       result_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pfg_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [pfg_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [pfg_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int unsigned AW = $clog2(PANCAKE_COUNT);

  logic [pfg_pkg::GI_W-1:0] gap_ignore_q;
  logic                     search_forward_q;
  logic                     dual_present_q;
  logic                     cfg_we;
  logic [1:0]               reg_idx;
  pfg_pkg::cfg_t            cfg;
  pfg_pkg::cmd_t            cmd;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ignore_q     <= '0;
      search_forward_q <= 1'b1;
      dual_present_q   <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx)
        pfg_pkg::REG_GAP_IGNORE:     gap_ignore_q     <= pwdata[pfg_pkg::GI_W-1:0];
        pfg_pkg::REG_SEARCH_FORWARD: search_forward_q <= pwdata[0];
        pfg_pkg::REG_DUAL_PRESENT:   dual_present_q   <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pfg_pkg::REG_GAP_IGNORE:     prdata = pfg_pkg::APB_DATA_W'(gap_ignore_q);
      pfg_pkg::REG_SEARCH_FORWARD: prdata = pfg_pkg::APB_DATA_W'(search_forward_q);
      pfg_pkg::REG_DUAL_PRESENT:   prdata = pfg_pkg::APB_DATA_W'(dual_present_q);
      default:                     prdata = '0;
    endcase
  end

  assign cfg.gap_ignore     = gap_ignore_q;
  assign cfg.search_forward = search_forward_q;
  assign cfg.dual_present   = dual_present_q;

  pfg_ctrl #(
    .PANCAKE_COUNT (PANCAKE_COUNT),
    .AW            (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .action_i    (item_i.action),
    .position_i  (item_i.position),
    .in_ready_o  (item_i.ready),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .cmd_o       (cmd)
  );

  pfg_datapath #(
    .PANCAKE_COUNT (PANCAKE_COUNT),
    .AW            (AW)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .cmd_i     (cmd),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .value_i   (item_i.value),
    .status_o  (result_o.status),
    .h_cost_o  (result_o.h_cost),
    .h_other_o (result_o.h_other),
    .g_cost_o  (result_o.g_cost),
    .f_cost_o  (result_o.f_cost),
    .f_bar_o   (result_o.f_bar)
  );

`ifndef NO_ASSERTIONS
  a_f_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.f_cost ==
      (pfg_pkg::F_W'(result_o.g_cost) + pfg_pkg::F_W'(result_o.h_cost)))
    else $error("f_cost does not match g_cost plus h_cost");

  a_fbar_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.f_bar ==
      $signed({2'b00, result_o.g_cost, 1'b0} + pfg_pkg::FBAR_W'(result_o.h_cost)
              - pfg_pkg::FBAR_W'(result_o.h_other)))
    else $error("f_bar does not match its terms");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.stk_we || cmd.dual_we) |-> !item_i.ready)
    else $error("table write while ready for a new transaction");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !item_i.ready)
    else $error("second transaction taken while one is in flight");
`endif

endmodule

FILE: rtl/core/pfg_ctrl.sv
module pfg_ctrl #(
  parameter int unsigned PANCAKE_COUNT = pfg_pkg::DEFAULT_PANCAKE_COUNT,
  parameter int unsigned AW            = $clog2(PANCAKE_COUNT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [pfg_pkg::ACTION_W-1:0]  action_i,
  input  logic [pfg_pkg::POS_W-1:0]     position_i,
  output logic                          in_ready_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [AW-1:0]                 rd_addr_o,
  output logic [AW-1:0]                 wr_addr_o,
  output pfg_pkg::cmd_t                 cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_EVAL  = 4'd2;
  localparam logic [3:0] ST_FRD   = 4'd3;
  localparam logic [3:0] ST_WAIT1 = 4'd4;
  localparam logic [3:0] ST_WAIT2 = 4'd5;
  localparam logic [3:0] ST_FUPD  = 4'd6;
  localparam logic [3:0] ST_SRLO  = 4'd7;
  localparam logic [3:0] ST_SRHI  = 4'd8;
  localparam logic [3:0] ST_SWLO  = 4'd9;
  localparam logic [3:0] ST_SWHI  = 4'd10;
  localparam logic [3:0] ST_FIN   = 4'd11;

  logic [3:0]                     state_q, state_d;
  logic [pfg_pkg::ACTION_W-1:0]   act_q, act_d;
  logic [pfg_pkg::POS_W-1:0]      pos_q, pos_d;
  logic [AW-1:0]                  cnt_q, cnt_d;
  logic [1:0]                     ph_q, ph_d;
  logic [AW-1:0]                  lo_q, lo_d;
  logic [AW-1:0]                  hi_q, hi_d;
  logic                           ovalid_q, ovalid_d;

  logic pos_ok;
  logic flip_ok;
  logic flip_ok_in;
  logic pos_last;

  assign pos_ok     = (pos_q != '0) && (int'(pos_q) <= PANCAKE_COUNT);
  assign flip_ok    = (int'(pos_q) >= 2) && (int'(pos_q) <= PANCAKE_COUNT);
  assign flip_ok_in = (int'(position_i) >= 2) && (int'(position_i) <= PANCAKE_COUNT);
  assign pos_last   = (int'(pos_q) == PANCAKE_COUNT);

  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    ph_d       = ph_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    cmd_o      = '0;
    rd_addr_o  = '0;
    wr_addr_o  = '0;
    in_ready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          act_d      = action_i;
          pos_d      = position_i;
          cnt_d      = '0;
          ph_d       = '0;
          case (action_i)
            pfg_pkg::ACT_LOAD_STACK: state_d = ST_LOAD;
            pfg_pkg::ACT_LOAD_DUAL:  state_d = ST_LOAD;
            pfg_pkg::ACT_EVAL:       state_d = ST_EVAL;
            default:                 state_d = flip_ok_in ? ST_FRD : ST_FIN;
          endcase
        end
      end
      ST_LOAD: begin
        cmd_o.stk_we  = pos_ok && (act_q == pfg_pkg::ACT_LOAD_STACK);
        cmd_o.dual_we = pos_ok && (act_q == pfg_pkg::ACT_LOAD_DUAL);
        cmd_o.wr_src  = pfg_pkg::WS_VALUE;
        wr_addr_o     = AW'(int'(pos_q) - 1);
        state_d       = ST_FIN;
      end
      ST_EVAL: begin
        rd_addr_o = cnt_q;
        if (cnt_q == '0) begin
          cmd_o.rd_kind = pfg_pkg::RK_FIRST;
        end else if (cnt_q == AW'(PANCAKE_COUNT - 1)) begin
          cmd_o.rd_kind = pfg_pkg::RK_LAST;
        end else begin
          cmd_o.rd_kind = pfg_pkg::RK_MID;
        end
        if (cnt_q == AW'(PANCAKE_COUNT - 1)) begin
          state_d = ST_WAIT1;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_FRD: begin
        case (ph_q)
          2'd0: begin
            rd_addr_o     = '0;
            cmd_o.rd_kind = pfg_pkg::RK_TOP;
          end
          2'd1: begin
            rd_addr_o     = AW'(int'(pos_q) - 1);
            cmd_o.rd_kind = pfg_pkg::RK_AT;
          end
          default: begin
            rd_addr_o     = AW'(int'(pos_q));
            cmd_o.rd_kind = pfg_pkg::RK_BELOW;
          end
        endcase
        // at the bottom the neighbor is virtual and needs no read
        if ((ph_q == 2'd1 && pos_last) || ph_q == 2'd2) begin
          state_d = ST_WAIT1;
        end else begin
          ph_d = ph_q + 2'd1;
        end
      end
      ST_WAIT1: begin
        state_d = ST_WAIT2;
      end
      ST_WAIT2: begin
        state_d = (act_q == pfg_pkg::ACT_FLIP) ? ST_FUPD : ST_FIN;
      end
      ST_FUPD: begin
        cmd_o.flip_upd      = 1'b1;
        cmd_o.below_virtual = pos_last;
        lo_d                = '0;
        hi_d                = AW'(int'(pos_q) - 1);
        state_d             = ST_SRLO;
      end
      ST_SRLO: begin
        rd_addr_o = lo_q;
        state_d   = ST_SRHI;
      end
      ST_SRHI: begin
        rd_addr_o      = hi_q;
        cmd_o.tmp_load = 1'b1;
        state_d        = ST_SWLO;
      end
      ST_SWLO: begin
        cmd_o.stk_we = 1'b1;
        cmd_o.wr_src = pfg_pkg::WS_RDATA;
        wr_addr_o    = lo_q;
        state_d      = ST_SWHI;
      end
      ST_SWHI: begin
        cmd_o.stk_we = 1'b1;
        cmd_o.wr_src = pfg_pkg::WS_TMP;
        wr_addr_o    = hi_q;
        lo_d         = lo_q + AW'(1);
        hi_d         = hi_q - AW'(1);
        state_d      = (int'(lo_q) + 2 < int'(hi_q)) ? ST_SRLO : ST_FIN;
      end
      ST_FIN: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.status   = (act_q == pfg_pkg::ACT_FLIP) && !flip_ok;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  assign out_valid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      act_q    <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      ph_q     <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      act_q    <= act_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      ph_q     <= ph_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

FILE: rtl/core/pfg_datapath.sv
module pfg_datapath #(
  parameter int unsigned PANCAKE_COUNT = pfg_pkg::DEFAULT_PANCAKE_COUNT,
  parameter int unsigned AW            = $clog2(PANCAKE_COUNT)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pfg_pkg::cfg_t                       cfg_i,
  input  pfg_pkg::cmd_t                       cmd_i,
  input  logic [AW-1:0]                       rd_addr_i,
  input  logic [AW-1:0]                       wr_addr_i,
  input  logic [pfg_pkg::VAL_W-1:0]           value_i,
  output logic                                status_o,
  output logic [pfg_pkg::BOUND_W-1:0]         h_cost_o,
  output logic [pfg_pkg::BOUND_W-1:0]         h_other_o,
  output logic [pfg_pkg::G_W-1:0]             g_cost_o,
  output logic [pfg_pkg::F_W-1:0]             f_cost_o,
  output logic signed [pfg_pkg::FBAR_W-1:0]   f_bar_o
);

  localparam int unsigned VW = pfg_pkg::VAL_W;
  localparam int unsigned BW = pfg_pkg::BOUND_W;
  localparam int unsigned CW = pfg_pkg::CMP_W;
  localparam logic [CW-1:0] NP1 = CW'(PANCAKE_COUNT + 1);

  logic [VW-1:0] stk_mem  [PANCAKE_COUNT];
  logic [VW-1:0] dual_mem [PANCAKE_COUNT];

  logic [VW-1:0]       val_q;
  logic [VW-1:0]       tmp_q;
  logic [VW-1:0]       stk1_q;
  logic [VW-1:0]       stk2_q;
  logic [VW-1:0]       dual2_q;
  logic                rng2_q;
  pfg_pkg::rd_kind_e   kind1_q;
  pfg_pkg::rd_kind_e   kind2_q;

  logic [VW-1:0]       wr_data;
  logic [AW-1:0]       dual_addr;
  logic                rng1;

  logic [BW-1:0]       fcnt_q, dcnt_q;
  logic [VW-1:0]       prev_s_q, prev_d_q;
  logic [VW-1:0]       top_s_q, top_d_q, at_s_q, at_d_q, bel_s_q, bel_d_q;

  logic [BW-1:0]       here_q, here_d;
  logic [BW-1:0]       there_q, there_d;
  logic [pfg_pkg::G_W-1:0] g_q, g_d;

  logic                off;
  logic [CW-1:0]       cur_s, cur_d, prv_s, prv_d;
  logic                eval_slot;
  logic                pair_ign;
  logic [1:0]          finc, dinc;
  logic [BW-1:0]       fbase, dbase, fsum, dsum, fres, dres;

  logic [CW-1:0]       top_s, top_d, at_s, at_d, bel_s, bel_d;
  logic                ign_t, ign_a, ign_b;
  logic [BW-1:0]       here_fwd, here_dual, there_fwd, there_dual;

  always_comb begin
    case (cmd_i.wr_src)
      pfg_pkg::WS_VALUE: wr_data = val_q;
      pfg_pkg::WS_RDATA: wr_data = stk1_q;
      pfg_pkg::WS_TMP:   wr_data = tmp_q;
      default:           wr_data = val_q;
    endcase
  end

  assign rng1      = (stk1_q != '0) && (int'(stk1_q) <= PANCAKE_COUNT);
  assign dual_addr = AW'(int'(stk1_q) - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.stk_we) begin
      stk_mem[wr_addr_i] <= wr_data;
    end
    if (cmd_i.dual_we) begin
      dual_mem[wr_addr_i] <= val_q;
    end
    stk1_q  <= stk_mem[rd_addr_i];
    dual2_q <= dual_mem[dual_addr];
  end

  always_ff @(posedge clk_i) begin
    stk2_q <= stk1_q;
    rng2_q <= rng1;
    if (cmd_i.take) begin
      val_q <= value_i;
    end
    if (cmd_i.tmp_load) begin
      tmp_q <= stk1_q;
    end
  end

  assign off = (cfg_i.gap_ignore == {pfg_pkg::GI_W{1'b1}});

  // stream stage: one stack entry and its dual value per cycle
  always_comb begin
    cur_s     = CW'(stk2_q);
    cur_d     = rng2_q ? CW'(dual2_q) : '0;
    prv_s     = CW'(prev_s_q);
    prv_d     = CW'(prev_d_q);
    eval_slot = (kind2_q == pfg_pkg::RK_FIRST) || (kind2_q == pfg_pkg::RK_MID) ||
                (kind2_q == pfg_pkg::RK_LAST);
    pair_ign  = pfg_pkg::is_ignored(cur_s, cfg_i.gap_ignore) ||
                pfg_pkg::is_ignored(prv_s, cfg_i.gap_ignore);
    finc      = '0;
    dinc      = '0;
    if (kind2_q != pfg_pkg::RK_FIRST && !pair_ign) begin
      finc = {1'b0, pfg_pkg::gap_far(cur_s, prv_s)};
      dinc = {1'b0, pfg_pkg::gap_far(cur_d, prv_d)};
    end
    if (kind2_q == pfg_pkg::RK_LAST && !pfg_pkg::is_ignored(cur_s, cfg_i.gap_ignore)) begin
      finc = finc + {1'b0, pfg_pkg::gap_far(NP1, cur_s)};
      dinc = dinc + {1'b0, pfg_pkg::gap_far(NP1, cur_d)};
    end
    fbase = (kind2_q == pfg_pkg::RK_FIRST) ? '0 : fcnt_q;
    dbase = (kind2_q == pfg_pkg::RK_FIRST) ? '0 : dcnt_q;
    fsum  = pfg_pkg::sat_add(fbase, finc);
    dsum  = pfg_pkg::sat_add(dbase, dinc);
    fres  = off ? '0 : fsum;
    dres  = (off || !cfg_i.dual_present) ? '0 : dsum;
  end

  always_ff @(posedge clk_i) begin
    if (eval_slot) begin
      fcnt_q   <= fsum;
      dcnt_q   <= dsum;
      prev_s_q <= stk2_q;
      prev_d_q <= cur_d[VW-1:0];
    end
    case (kind2_q)
      pfg_pkg::RK_TOP: begin
        top_s_q <= stk2_q;
        top_d_q <= cur_d[VW-1:0];
      end
      pfg_pkg::RK_AT: begin
        at_s_q <= stk2_q;
        at_d_q <= cur_d[VW-1:0];
      end
      pfg_pkg::RK_BELOW: begin
        bel_s_q <= stk2_q;
        bel_d_q <= cur_d[VW-1:0];
      end
      default: begin
      end
    endcase
  end

  // incremental update before the prefix reversal
  always_comb begin
    top_s = CW'(top_s_q);
    top_d = CW'(top_d_q);
    at_s  = CW'(at_s_q);
    at_d  = CW'(at_d_q);
    bel_s = cmd_i.below_virtual ? NP1 : CW'(bel_s_q);
    bel_d = cmd_i.below_virtual ? NP1 : CW'(bel_d_q);
    ign_t = pfg_pkg::is_ignored(top_s, cfg_i.gap_ignore);
    ign_a = pfg_pkg::is_ignored(at_s, cfg_i.gap_ignore);
    ign_b = pfg_pkg::is_ignored(bel_s, cfg_i.gap_ignore);
    here_fwd   = pfg_pkg::step_bound(here_q, ign_t, ign_a, ign_b, top_s, at_s, bel_s);
    here_dual  = pfg_pkg::step_bound(here_q, ign_t, ign_a, ign_b, top_d, at_d, bel_d);
    there_fwd  = pfg_pkg::step_bound(there_q, ign_t, ign_a, ign_b, top_s, at_s, bel_s);
    there_dual = pfg_pkg::step_bound(there_q, ign_t, ign_a, ign_b, top_d, at_d, bel_d);
  end

  always_comb begin
    here_d  = here_q;
    there_d = there_q;
    g_d     = g_q;
    if (kind2_q == pfg_pkg::RK_LAST) begin
      here_d  = cfg_i.search_forward ? fres : dres;
      there_d = cfg_i.search_forward ? dres : fres;
      g_d     = '0;
    end else if (cmd_i.flip_upd) begin
      if (off) begin
        here_d  = '0;
        there_d = '0;
      end else if (cfg_i.search_forward) begin
        here_d  = here_fwd;
        there_d = cfg_i.dual_present ? there_dual : there_q;
      end else begin
        here_d  = cfg_i.dual_present ? here_dual : here_q;
        there_d = there_fwd;
      end
      g_d = (g_q == '1) ? g_q : g_q + pfg_pkg::G_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind1_q <= pfg_pkg::RK_NONE;
      kind2_q <= pfg_pkg::RK_NONE;
      here_q  <= '0;
      there_q <= '0;
      g_q     <= '0;
    end else begin
      kind1_q <= cmd_i.rd_kind;
      kind2_q <= kind1_q;
      here_q  <= here_d;
      there_q <= there_d;
      g_q     <= g_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o  <= cmd_i.status;
      h_cost_o  <= here_q;
      h_other_o <= there_q;
      g_cost_o  <= g_q;
      f_cost_o  <= pfg_pkg::F_W'(g_q) + pfg_pkg::F_W'(here_q);
      f_bar_o   <= $signed({2'b00, g_q, 1'b0} + pfg_pkg::FBAR_W'(here_q)
                           - pfg_pkg::FBAR_W'(there_q));
    end
  end

endmodule
